// ===== rtl/core/dse_pkg.sv =====
`timescale 1ns / 1ps

package dse_pkg;

  localparam int DICT_ENTRIES    = 8;
  localparam int KEY_MAX         = 4;
  localparam int KEY_FIELD_BYTES = 4;
  localparam int ENTRY_REGS      = 8;
  localparam int HIST_DEPTH      = KEY_MAX + 1;
  localparam int KEY_LIM         = (KEY_MAX < KEY_FIELD_BYTES) ? KEY_MAX : KEY_FIELD_BYTES;
  localparam int CNT_W           = $clog2(HIST_DEPTH + 1);
  localparam int ENTRY_W         = 43;
  localparam int IDX_W           = $clog2(ENTRY_REGS);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [7:0]         byte_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef struct packed {
    logic push;
    logic consume;
    logic move;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic prefix_full;
    logic emit;
    logic held_valid;
    logic out_free;
  } status_t;

  typedef struct packed {
    cnt_t  plen;
    logic  found;
    cnt_t  wlen;
    byte_t wcode;
  } match_t;

  function automatic cnt_t key_len(entry_t e);
    logic [2:0] raw;
    raw = e[10:8];
    if (int'(raw) > KEY_LIM) begin
      return cnt_t'(KEY_LIM);
    end
    return cnt_t'(raw);
  endfunction

  function automatic byte_t key_byte(entry_t e, int i);
    return e[11 + 8 * (i % KEY_FIELD_BYTES) +: 8];
  endfunction

  function automatic byte_t entry_code(entry_t e);
    return e[7:0];
  endfunction

endpackage

// ===== rtl/core/dse_if.sv =====
`timescale 1ns / 1ps

interface dse_in_if;
  logic  valid;
  logic  ready;
  logic  opcode;
  logic  [7:0] literal;

  modport source (output valid, output opcode, output literal, input ready);
  modport sink (input valid, input opcode, input literal, output ready);
endinterface

interface dse_out_if;
  logic  valid;
  logic  ready;
  logic  [7:0] code;
  logic  last;

  modport source (output valid, output code, output last, input ready);
  modport sink (input valid, input code, input last, output ready);
endinterface

// ===== rtl/core/dse_match.sv =====
`timescale 1ns / 1ps

module dse_match (
  input  dse_pkg::byte_t  hist_i [dse_pkg::HIST_DEPTH],
  input  dse_pkg::cnt_t   count_i,
  input  dse_pkg::entry_t entries_i [dse_pkg::ENTRY_REGS],
  output dse_pkg::match_t match_o
);

  dse_pkg::cnt_t klen  [dse_pkg::DICT_ENTRIES];
  dse_pkg::cnt_t agree [dse_pkg::DICT_ENTRIES];
  logic          run;

  // leading agreement of history with each key
  always_comb begin
    for (int e = 0; e < dse_pkg::DICT_ENTRIES; e++) begin
      klen[e]  = dse_pkg::key_len(entries_i[e]);
      agree[e] = '0;
      run      = 1'b1;
      for (int i = 0; i < dse_pkg::KEY_LIM; i++) begin
        if (run && (dse_pkg::cnt_t'(i) < count_i) && (dse_pkg::cnt_t'(i) < klen[e]) &&
            (hist_i[i] == dse_pkg::key_byte(entries_i[e], i))) begin
          agree[e] = dse_pkg::cnt_t'(i + 1);
        end else begin
          run = 1'b0;
        end
      end
    end
  end

  // longest prefix and longest whole key, lowest index wins ties
  always_comb begin
    match_o = '0;
    for (int e = 0; e < dse_pkg::DICT_ENTRIES; e++) begin
      if (agree[e] > match_o.plen) begin
        match_o.plen = agree[e];
      end
      if ((agree[e] == klen[e]) && (agree[e] > match_o.wlen)) begin
        match_o.wlen  = agree[e];
        match_o.wcode = dse_pkg::entry_code(entries_i[e]);
        match_o.found = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/dse_datapath.sv =====
`timescale 1ns / 1ps

module dse_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  dse_pkg::idx_t     cfg_idx_i,
  input  dse_pkg::entry_t   cfg_data_i,
  input  dse_pkg::byte_t    in_literal_i,
  input  dse_pkg::cmd_t     cmd_i,
  output dse_pkg::status_t  status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dse_pkg::byte_t    out_code_o,
  output logic              out_last_o
);

  dse_pkg::entry_t entries_q [dse_pkg::ENTRY_REGS];
  dse_pkg::byte_t  hist_q [dse_pkg::HIST_DEPTH];
  dse_pkg::byte_t  hist_d [dse_pkg::HIST_DEPTH];
  dse_pkg::cnt_t   count_q, count_d;
  logic            held_valid_q, held_valid_d;
  dse_pkg::byte_t  held_code_q, held_code_d;
  logic            out_valid_q, out_valid_d;
  dse_pkg::byte_t  out_code_q, out_code_d;
  logic            out_last_q, out_last_d;

  dse_pkg::match_t match;
  dse_pkg::cnt_t   drop_len;
  logic            emit;
  dse_pkg::byte_t  emit_code;
  logic            out_free;

  dse_match u_match (
    .hist_i    (hist_q),
    .count_i   (count_q),
    .entries_i (entries_q),
    .match_o   (match)
  );

  assign drop_len  = match.found ? match.wlen : dse_pkg::cnt_t'(1);
  assign emit      = !match.found || (match.wcode != 8'h00);
  assign emit_code = match.found ? match.wcode : hist_q[0];
  assign out_free  = !out_valid_q || out_ready_i;

  assign status_o.count_zero  = (count_q == '0);
  assign status_o.prefix_full = (match.plen == count_q);
  assign status_o.emit        = emit;
  assign status_o.held_valid  = held_valid_q;
  assign status_o.out_free    = out_free;

  always_comb begin
    hist_d       = hist_q;
    count_d      = count_q;
    held_valid_d = held_valid_q;
    held_code_d  = held_code_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_code_d   = out_code_q;
    out_last_d   = out_last_q;

    if (cmd_i.push) begin
      for (int i = 0; i < dse_pkg::HIST_DEPTH; i++) begin
        if (count_q == dse_pkg::cnt_t'(i)) begin
          hist_d[i] = in_literal_i;
        end
      end
      count_d = count_q + dse_pkg::cnt_t'(1);
    end

    if (cmd_i.move) begin
      out_valid_d  = 1'b1;
      out_code_d   = held_code_q;
      out_last_d   = cmd_i.last;
      held_valid_d = 1'b0;
    end

    if (cmd_i.consume) begin
      // drop consumed bytes from the front
      for (int k = 1; k <= dse_pkg::KEY_LIM; k++) begin
        if (drop_len == dse_pkg::cnt_t'(k)) begin
          for (int i = 0; i + k < dse_pkg::HIST_DEPTH; i++) begin
            hist_d[i] = hist_q[i + k];
          end
        end
      end
      count_d = count_q - drop_len;
      if (emit) begin
        held_valid_d = 1'b1;
        held_code_d  = emit_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < dse_pkg::ENTRY_REGS; e++) begin
        entries_q[e] <= '0;
      end
      for (int i = 0; i < dse_pkg::HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      count_q      <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (int'(cfg_idx_i) < dse_pkg::ENTRY_REGS)) begin
        entries_q[cfg_idx_i] <= cfg_data_i;
      end
      hist_q       <= hist_d;
      count_q      <= count_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_code_q <= held_code_d;
    out_code_q  <= out_code_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= dse_pkg::HIST_DEPTH)
    else $error("history count overflow");

  a_move_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |-> out_free)
    else $error("output beat overwritten");

  a_consume_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.consume |-> (count_q != '0) && (drop_len <= count_q))
    else $error("consume beyond history");

endmodule

// ===== rtl/core/dse_ctrl.sv =====
`timescale 1ns / 1ps

module dse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_opcode_i,
  output logic             in_ready_o,
  input  dse_pkg::status_t status_i,
  output dse_pkg::cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   flush_q, flush_d;
  logic   done;

  assign in_ready_o = (state_q == ST_IDLE);
  assign done = status_i.count_zero || (!flush_q && status_i.prefix_full);

  always_comb begin
    state_d = state_q;
    flush_d = flush_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.push = (in_opcode_i == dse_pkg::OP_PUSH);
          flush_d    = (in_opcode_i == dse_pkg::OP_FLUSH);
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (done) begin
          if (!status_i.held_valid) begin
            state_d = ST_IDLE;
          end else if (status_i.out_free) begin
            cmd_o.move = 1'b1;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (status_i.emit && status_i.held_valid) begin
          if (status_i.out_free) begin
            cmd_o.move    = 1'b1;
            cmd_o.consume = 1'b1;
          end
        end else begin
          cmd_o.consume = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !status_i.held_valid)
    else $error("code left behind at idle");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.move && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("last beat did not end the item");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EVAL))
    else $error("accepted item not evaluated");

endmodule

// ===== rtl/core/dictionary_substitution_encoder.sv =====
`timescale 1ns / 1ps

// Greedy longest-match dictionary encoder. Each input beat either pushes one byte into a
// history of up to five bytes or flushes it; eight 43-bit entry registers (code 7:0, key
// length 10:8, key bytes 42:11) are written through the cfg port; the user must write
// them only while the block is idle, which it does not enforce. An item is taken in, then
// worked off in history steps (each emitted code, literal or silent code-zero match); its
// final code leaves in the step that finds the history settled, and no new item is taken
// before that. The single key matcher judges all entries once per cycle. Back-pressure
// stalls the steps that move a code out. Codes go out through an output register, the last
// beat of each item flagged by last; an item that yields no code produces no beat.

module dictionary_substitution_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  dse_in_if.sink              in_i,
  dse_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  dse_pkg::idx_t       cfg_idx_i,
  input  dse_pkg::entry_t     cfg_data_i
);

  dse_pkg::cmd_t    cmd;
  dse_pkg::status_t status;

  dse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dse_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_literal_i (in_i.literal),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_code_o   (out_o.code),
    .out_last_o   (out_o.last)
  );

endmodule
